/* rtl/core/lfu_page_replacement_assert.svh */
// Assertion macros shared by the LFU table
`ifndef LFU_PAGE_REPLACEMENT_ASSERT_SVH
`define LFU_PAGE_REPLACEMENT_ASSERT_SVH

// same-cycle implication, held off while in reset
`define LFU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while in reset
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lfu_pkg.sv */
package lfu_pkg;

    localparam int PAGE_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int CFG_W   = 5;
    localparam int FAULT_W = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic load;    // take the word, restart the walk
        logic read;    // read the frame at the walk address
        logic update;  // commit the decision and present the result
    } t_dp_cmd;

    typedef struct packed {
        logic last;    // walk address is the last active frame
    } t_dp_stat;

endpackage

/* rtl/core/lfu_ctrl.sv */
module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    output logic     o_busy,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_WALK;
                end
            end
            ST_WALK: begin
                o_cmd.read = 1'b1;
                if (i_stat.last) begin
                    n_state = ST_WAIT;
                end
            end
            // last read's compare lands here
            ST_WAIT: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

/* rtl/core/lfu_datapath.sv */
module lfu_datapath
    import lfu_pkg::*;
#(
    parameter int FRAMES     = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_frames_in_use,
    input  logic [PAGE_W-1:0]  i_page,
    output logic               o_valid,
    output logic               o_hit,
    output logic [SLOT_W-1:0]  o_slot,
    output logic               o_evicted_valid,
    output logic [PAGE_W-1:0]  o_evicted_page,
    output logic [FAULT_W-1:0] o_fault_total
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int NW = 9;

    // frame store
    logic [PAGE_W-1:0]     r_mem_page  [FRAMES];
    logic [COUNT_BITS-1:0] r_mem_count [FRAMES];
    logic [FRAMES-1:0]     r_valid;

    logic [CFG_W-1:0]   r_cfg;
    logic [PAGE_W-1:0]  r_page;
    logic [IW-1:0]      r_addr;
    logic [IW-1:0]      r_last;
    logic [FAULT_W-1:0] r_fault;

    // read stage
    logic                  r_rd_live;
    logic                  r_rd_valid;
    logic [IW-1:0]         r_rd_idx;
    logic [PAGE_W-1:0]     r_rd_page;
    logic [COUNT_BITS-1:0] r_rd_count;

    // search state
    logic                  r_found;
    logic [IW-1:0]         r_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_count;
    logic                  r_have_empty;
    logic [IW-1:0]         r_empty_idx;
    logic                  r_have_min;
    logic [IW-1:0]         r_min_idx;
    logic [COUNT_BITS-1:0] r_min_count;
    logic [PAGE_W-1:0]     r_min_page;

    // result
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [SLOT_W-1:0]     r_out_slot;
    logic                  r_out_ev_valid;
    logic [PAGE_W-1:0]     r_out_ev_page;

    logic [NW-1:0]         w_active;
    logic [IW-1:0]         w_slot;
    logic [COUNT_BITS-1:0] w_count;
    logic                  w_evict;

    // zero acts as one, anything above the table size as the table size
    always_comb begin
        if (r_cfg == '0) begin
            w_active = NW'(1);
        end else if (NW'(r_cfg) > NW'(FRAMES)) begin
            w_active = NW'(FRAMES);
        end else begin
            w_active = NW'(r_cfg);
        end
    end

    assign o_stat.last = (r_addr == r_last);

    always_comb begin
        w_evict = 1'b0;
        if (r_found) begin
            w_slot  = r_hit_idx;
            w_count = (&r_hit_count) ? r_hit_count : r_hit_count + COUNT_BITS'(1);
        end else begin
            w_count = COUNT_BITS'(1);
            if (r_have_empty) begin
                w_slot = r_empty_idx;
            end else begin
                w_slot  = r_min_idx;
                w_evict = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_valid     <= '0;
            r_fault     <= '0;
            r_rd_live   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_frames_in_use;
            end
            r_rd_live   <= i_cmd.read;
            r_out_valid <= i_cmd.update;
            if (i_cmd.update && !r_found) begin
                r_valid[w_slot] <= 1'b1;
                r_fault         <= r_fault + FAULT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_page  <= r_mem_page[r_addr];
            r_rd_count <= r_mem_count[r_addr];
        end
        if (i_cmd.update) begin
            r_mem_count[w_slot] <= w_count;
            if (!r_found) begin
                r_mem_page[w_slot] <= r_page;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page       <= i_page;
            r_addr       <= '0;
            r_last       <= IW'(w_active - NW'(1));
            r_found      <= 1'b0;
            r_have_empty <= 1'b0;
            r_have_min   <= 1'b0;
        end else begin
            if (i_cmd.read) begin
                r_addr <= r_addr + IW'(1);
            end
            if (r_rd_live) begin
                if (r_rd_valid) begin
                    if (!r_found && r_rd_page == r_page) begin
                        r_found     <= 1'b1;
                        r_hit_idx   <= r_rd_idx;
                        r_hit_count <= r_rd_count;
                    end
                    // strict less-than keeps the lowest index on a tie
                    if (!r_have_min || r_rd_count < r_min_count) begin
                        r_have_min  <= 1'b1;
                        r_min_idx   <= r_rd_idx;
                        r_min_count <= r_rd_count;
                        r_min_page  <= r_rd_page;
                    end
                end else if (!r_have_empty) begin
                    r_have_empty <= 1'b1;
                    r_empty_idx  <= r_rd_idx;
                end
            end
        end
        if (i_cmd.read) begin
            r_rd_valid <= r_valid[r_addr];
            r_rd_idx   <= r_addr;
        end
        if (i_cmd.update) begin
            r_out_hit      <= r_found;
            r_out_slot     <= SLOT_W'(w_slot);
            r_out_ev_valid <= w_evict;
            r_out_ev_page  <= w_evict ? r_min_page : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_slot          = r_out_slot;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_fault_total   = r_fault;

endmodule

/* rtl/core/lfu_page_replacement.sv */
// A word is taken in the idle state. The walk then reads one frame per cycle through the
// table's single read port over the N active frames, N = active frames; a wait state lets
// the compare of the last read land and an update state commits the decision. The result
// shows in the idle state, which can take the next word; no word is taken while busy.
// Results are shown for one cycle on o_valid; the receiver cannot stall.
// Synchronous active-low reset clears valid marks, fault total and control;
// frames_in_use returns to 16.
`include "lfu_page_replacement_assert.svh"

module lfu_page_replacement
    import lfu_pkg::*;
#(
    parameter int FRAMES     = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [PAGE_W-1:0]  i_page,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_frames_in_use,
    output logic               o_valid,
    output logic               o_hit,
    output logic [SLOT_W-1:0]  o_slot,
    output logic               o_evicted_valid,
    output logic [PAGE_W-1:0]  o_evicted_page,
    output logic [FAULT_W-1:0] o_fault_total
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    lfu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    lfu_datapath #(
        .FRAMES     (FRAMES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_frames_in_use (i_cfg_frames_in_use),
        .i_page              (i_page),
        .o_valid             (o_valid),
        .o_hit               (o_hit),
        .o_slot              (o_slot),
        .o_evicted_valid     (o_evicted_valid),
        .o_evicted_page      (o_evicted_page),
        .o_fault_total       (o_fault_total)
    );

    `LFU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy,
        "accepted word did not raise busy")
    `LFU_ASSERT_SAME(a_result_idle, i_clk, i_rst_n, o_valid, !busy && !w_cmd.read,
        "result word while walk still active")
    `LFU_ASSERT_SAME(a_fault_step, i_clk, i_rst_n, o_valid && !o_hit,
        o_fault_total == $past(o_fault_total) + 32'd1, "fault total did not step on a fault")
    `LFU_ASSERT_SAME(a_hit_hold, i_clk, i_rst_n, o_valid && o_hit,
        $stable(o_fault_total) && !o_evicted_valid, "hit moved fault total or evicted")

endmodule

/* sim/testbench.sv */
module testbench;
    import lfu_pkg::*;

    localparam int FRAMES = 16;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;
    localparam int SAT_HITS = 40;
    localparam int PHASE_WORDS = 137;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               ev_valid;
        logic [PAGE_W-1:0]  ev_page;
        logic [FAULT_W-1:0] faults;
    } t_lookup;

    typedef struct packed {
        logic [PAGE_W-1:0] pg;
        logic              typed;
        t_lookup           want;
    } t_probe_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [PAGE_W-1:0]  i_page = '0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_W-1:0]   i_cfg_frames_in_use = '0;
    logic               o_valid;
    logic               o_hit;
    logic [SLOT_W-1:0]  o_slot;
    logic               o_evicted_valid;
    logic [PAGE_W-1:0]  o_evicted_page;
    logic [FAULT_W-1:0] o_fault_total;

    lfu_page_replacement dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_page              (i_page),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_frames_in_use (i_cfg_frames_in_use),
        .o_valid             (o_valid),
        .o_hit               (o_hit),
        .o_slot              (o_slot),
        .o_evicted_valid     (o_evicted_valid),
        .o_evicted_page      (o_evicted_page),
        .o_fault_total       (o_fault_total)
    );

    always #10 i_clk = ~i_clk;

    // shadow copy of the frame table
    logic [PAGE_W-1:0]  tbl_page  [FRAMES];
    bit                 tbl_valid [FRAMES];
    logic [15:0]        tbl_count [FRAMES];
    logic [FAULT_W-1:0] faults_seen = '0;
    logic [CFG_W-1:0]   frames_cfg = CFG_RESET;

    t_lookup     pending [$];
    t_lookup     got_want;
    int          errors = 0;
    logic [15:0] pool [32];

    // reset state, then fill frames 2..15 with walking ones and evict the first of them
    t_probe_row probes [24] = '{
        '{16'h0000, 1'b1, '{1'b0, 4'd0,  1'b0, 16'h0000, 32'd1}},
        '{16'hFFFF, 1'b1, '{1'b0, 4'd1,  1'b0, 16'h0000, 32'd2}},
        '{16'h0000, 1'b1, '{1'b1, 4'd0,  1'b0, 16'h0000, 32'd2}},
        '{16'hFFFF, 1'b1, '{1'b1, 4'd1,  1'b0, 16'h0000, 32'd2}},
        '{16'h0000, 1'b1, '{1'b1, 4'd0,  1'b0, 16'h0000, 32'd2}},
        '{16'h0001, 1'b1, '{1'b0, 4'd2,  1'b0, 16'h0000, 32'd3}},
        '{16'h0002, 1'b1, '{1'b0, 4'd3,  1'b0, 16'h0000, 32'd4}},
        '{16'h0004, 1'b1, '{1'b0, 4'd4,  1'b0, 16'h0000, 32'd5}},
        '{16'h0008, 1'b1, '{1'b0, 4'd5,  1'b0, 16'h0000, 32'd6}},
        '{16'h0010, 1'b1, '{1'b0, 4'd6,  1'b0, 16'h0000, 32'd7}},
        '{16'h0020, 1'b1, '{1'b0, 4'd7,  1'b0, 16'h0000, 32'd8}},
        '{16'h0040, 1'b1, '{1'b0, 4'd8,  1'b0, 16'h0000, 32'd9}},
        '{16'h0080, 1'b1, '{1'b0, 4'd9,  1'b0, 16'h0000, 32'd10}},
        '{16'h0100, 1'b1, '{1'b0, 4'd10, 1'b0, 16'h0000, 32'd11}},
        '{16'h0200, 1'b1, '{1'b0, 4'd11, 1'b0, 16'h0000, 32'd12}},
        '{16'h0400, 1'b1, '{1'b0, 4'd12, 1'b0, 16'h0000, 32'd13}},
        '{16'h0800, 1'b1, '{1'b0, 4'd13, 1'b0, 16'h0000, 32'd14}},
        '{16'h1000, 1'b1, '{1'b0, 4'd14, 1'b0, 16'h0000, 32'd15}},
        '{16'h2000, 1'b1, '{1'b0, 4'd15, 1'b0, 16'h0000, 32'd16}},
        '{16'h1234, 1'b1, '{1'b0, 4'd2,  1'b1, 16'h0001, 32'd17}},
        '{16'h0002, 1'b1, '{1'b1, 4'd3,  1'b0, 16'h0000, 32'd17}},
        '{16'h8000, 1'b0, '0},
        '{16'h4000, 1'b0, '0},
        '{16'hFFFF, 1'b0, '0}
    };

    function automatic int active_count(input logic [CFG_W-1:0] v);
        if (v < 1) return 1;
        if (v > FRAMES) return FRAMES;
        return int'(v);
    endfunction

    // one lookup: match, first empty frame and least-used frame in a single walk
    function automatic t_lookup predict_lookup(input logic [PAGE_W-1:0] pg);
        int      n;
        int      empty_idx;
        int      min_idx;
        int      hit_idx;
        bit      found;
        bit      have_empty;
        t_lookup r;
        n = active_count(frames_cfg);
        empty_idx = 0;
        min_idx = 0;
        hit_idx = 0;
        found = 1'b0;
        have_empty = 1'b0;
        r = '0;
        for (int k = 0; k < n; k++) begin
            if (tbl_valid[k]) begin
                if (!found && tbl_page[k] == pg) begin
                    found = 1'b1;
                    hit_idx = k;
                end
                if (tbl_count[k] < tbl_count[min_idx] || !tbl_valid[min_idx])
                    min_idx = k;
            end else if (!have_empty) begin
                have_empty = 1'b1;
                empty_idx = k;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            r.slot = SLOT_W'(hit_idx);
            if (tbl_count[hit_idx] != COUNT_TOP)
                tbl_count[hit_idx] = tbl_count[hit_idx] + 16'd1;
        end else begin
            if (have_empty) begin
                r.slot = SLOT_W'(empty_idx);
            end else begin
                r.slot = SLOT_W'(min_idx);
                r.ev_valid = 1'b1;
                r.ev_page = tbl_page[min_idx];
            end
            tbl_page[r.slot] = pg;
            tbl_valid[r.slot] = 1'b1;
            tbl_count[r.slot] = 16'd1;
            faults_seen = faults_seen + 1'b1;
        end
        r.faults = faults_seen;
        return r;
    endfunction

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending.size() == 0) begin
                report("result word with nothing outstanding");
            end else begin
                got_want = pending.pop_front();
                check_field("hit", 32'(o_hit), 32'(got_want.hit));
                check_field("slot", 32'(o_slot), 32'(got_want.slot));
                check_field("evicted_valid", 32'(o_evicted_valid), 32'(got_want.ev_valid));
                check_field("evicted_page", 32'(o_evicted_page), 32'(got_want.ev_page));
                check_field("fault_total", 32'(o_fault_total), 32'(got_want.faults));
            end
        end
    end

    // start stays up while words follow back to back
    task automatic send_page(input logic [PAGE_W-1:0] pg, input bit typed,
                             input t_lookup want);
        t_lookup p;
        start <= 1'b1;
        i_page <= pg;
        do @(posedge i_clk); while (busy);
        p = predict_lookup(pg);
        pending.push_back(typed ? want : p);
    endtask

    task automatic idle_gap(input bit calm);
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (calm || r < 50) len = 0;
        else if (r < 85) len = $urandom_range(1, 3);
        else if (r < 97) len = $urandom_range(4, 20);
        else len = $urandom_range(21, 60);
        if (len > 0) begin
            start <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        do @(posedge i_clk); while (pending.size() != 0 || busy);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_frames_in_use <= v;
        frames_cfg = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_W-1:0] plan [11];
        logic [PAGE_W-1:0] pg;
        int  pool_n;
        bit  calm;
        for (int k = 0; k < FRAMES; k++) begin
            tbl_page[k] = '0;
            tbl_valid[k] = 1'b0;
            tbl_count[k] = '0;
        end
        for (int k = 0; k < 32; k++) pool[k] = 16'($urandom());
        plan = '{5'd31, 5'd0, 5'd4, 5'd16, 5'd17, 5'd1, 5'd8, 5'd15, 5'd2,
                 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // frame count left at its reset value here
        foreach (probes[k]) begin
            send_page(probes[k].pg, probes[k].typed, probes[k].want);
            idle_gap(1'b0);
        end

        // one frame active: hammer it back to back, then open a second
        // frame so a heavily used count must not look like the least used
        write_frames(5'd1);
        for (int k = 0; k < SAT_HITS; k++) send_page(16'hA5C3, 1'b0, '0);
        write_frames(5'd2);
        for (int k = 0; k < 30; k++) begin
            pg = ($urandom_range(0, 2) == 0) ? 16'hA5C3 : 16'($urandom());
            send_page(pg, 1'b0, '0);
            idle_gap(1'b0);
        end

        foreach (plan[p]) begin
            write_frames(plan[p]);
            pool_n = active_count(plan[p]) + $urandom_range(1, 8);
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                // skewed choice from the pool keeps use counts uneven
                if ($urandom_range(0, 9) == 0) pg = 16'($urandom());
                else pg = pool[$urandom_range(0, $urandom_range(0, pool_n - 1))];
                send_page(pg, 1'b0, '0);
                if ($urandom_range(0, 49) == 0) drain();
                else idle_gap(calm);
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("lfu_page_replacement test passed");
        else
            $display("lfu_page_replacement test failed");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("lfu_page_replacement test failed");
        $finish;
    end

endmodule
